### hdl/rbsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared widths, types and helper functions for the ray/box slab test.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  localparam int CB = 32;               // coordinate width
  localparam int FB = 16;               // fraction bits
  localparam int DW = CB + 1;           // corner minus origin
  localparam int NW = CB + FB;          // numerator / quotient magnitude
  localparam int QW = NW + 1;           // signed slab distance
  localparam int PW = 2 * CB;           // product width
  localparam int MW = PW - FB + 1;      // scaled product, signed
  localparam int SW = MW + 1;           // scaled product plus origin
  localparam int IDX_BITS = 3;
  localparam int QUEUE_DEPTH = 4;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [QW-1:0] quot_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [MW-1:0] scl_t;
  typedef logic signed [SW-1:0] sum_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    coord_t [2:0] org;
    coord_t [2:0] dir;
    logic   [2:0] dz;
    logic         blocked;
    diff_t  [2:0] dlo;
    diff_t  [2:0] dhi;
  } item_t;

  typedef struct packed {
    coord_t [2:0] org;
    coord_t [2:0] dir;
    logic   [2:0] dz;
    logic         blocked;
  } side_t;

  typedef struct packed {
    logic  ok;
    quot_t n;
    quot_t f;
  } span_t;

  localparam coord_t COORD_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CB-1){1'b0}}};

  function automatic span_t span_merge(input span_t a, input span_t b);
    span_t r;
    r.ok = a.ok | b.ok;
    if (a.ok && b.ok) begin
      r.n = (a.n < b.n) ? b.n : a.n;
      r.f = (b.f < a.f) ? b.f : a.f;
    end else if (a.ok) begin
      r.n = a.n;
      r.f = a.f;
    end else begin
      r.n = b.n;
      r.f = b.f;
    end
    return r;
  endfunction

  function automatic coord_t sat_q(input quot_t v);
    coord_t r;
    if ((&v[QW-1:CB-1]) || !(|v[QW-1:CB-1])) begin
      r = coord_t'(v[CB-1:0]);
    end else begin
      r = v[QW-1] ? COORD_MIN : COORD_MAX;
    end
    return r;
  endfunction

  function automatic coord_t sat_s(input sum_t v);
    coord_t r;
    if ((&v[SW-1:CB-1]) || !(|v[SW-1:CB-1])) begin
      r = coord_t'(v[CB-1:0]);
    end else begin
      r = v[SW-1] ? COORD_MIN : COORD_MAX;
    end
    return r;
  endfunction

endpackage

### hdl/ray_box_slab_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Ray against axis-aligned box, slab method, signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Takes one ray per cycle and returns one result per cycle while out_ready
// stays high. Each accepted ray passes through the queue, then the six
// pipelined divider pipelines (one quotient bit per stage, 48 stages) that
// form the slab distances, then the reduction and hit point multiply stages.
// The user must write box corners through the cfg port only while no ray is
// in flight; the block itself does not enforce this. The queue depth is set
// by QUEUE_DEPTH.
module ray_box_slab_intersect #(
  parameter int QUEUE_DEPTH = rbsi_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rbsi_pkg::IDX_BITS-1:0]   cfg_index,
  input  logic [rbsi_pkg::CB-1:0]         cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rbsi_pkg::coord_t                in_origin_x,
  input  rbsi_pkg::coord_t                in_origin_y,
  input  rbsi_pkg::coord_t                in_origin_z,
  input  rbsi_pkg::coord_t                in_dir_x,
  input  rbsi_pkg::coord_t                in_dir_y,
  input  rbsi_pkg::coord_t                in_dir_z,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  output rbsi_pkg::coord_t                out_t_near,
  output rbsi_pkg::coord_t                out_hit_x,
  output rbsi_pkg::coord_t                out_hit_y,
  output rbsi_pkg::coord_t                out_hit_z
);

  rbsi_pkg::coord_t [2:0] box_min_r, box_max_r;
  rbsi_pkg::item_t        f_item, b_item;
  logic                   push, pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_min_r <= '0;
      box_max_r <= '0;
    end else if (cfg_valid) begin
      case (rbsi_pkg::reg_idx_t'(cfg_index))
        rbsi_pkg::REG_BOX_MIN_X: box_min_r[0] <= cfg_data;
        rbsi_pkg::REG_BOX_MIN_Y: box_min_r[1] <= cfg_data;
        rbsi_pkg::REG_BOX_MIN_Z: box_min_r[2] <= cfg_data;
        rbsi_pkg::REG_BOX_MAX_X: box_max_r[0] <= cfg_data;
        rbsi_pkg::REG_BOX_MAX_Y: box_max_r[1] <= cfg_data;
        rbsi_pkg::REG_BOX_MAX_Z: box_max_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  rbsi_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .org      ({in_origin_z, in_origin_y, in_origin_x}),
    .dir      ({in_dir_z, in_dir_y, in_dir_x}),
    .box_min  (box_min_r),
    .box_max  (box_max_r),
    .q_full   (q_full),
    .push     (push),
    .item     (f_item)
  );

  rbsi_fifo #(
    .WIDTH ($bits(rbsi_pkg::item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (f_item),
    .pop   (pop),
    .rdata (b_item),
    .full  (q_full),
    .empty (q_empty)
  );

  rbsi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (b_item),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_hit    (out_hit),
    .out_t_near (out_t_near),
    .out_hit_x  (out_hit_x),
    .out_hit_y  (out_hit_y),
    .out_hit_z  (out_hit_z)
  );

endmodule

### hdl/rbsi_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_fifo
// Small queue between the classify front and the arithmetic back.
// ----------------------------------------------------------------------------
module rbsi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### hdl/rbsi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_front
// Accepts a ray, flags flat axes and forms the corner minus origin terms.
// ----------------------------------------------------------------------------
module rbsi_front (
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rbsi_pkg::coord_t [2:0]  org,
  input  rbsi_pkg::coord_t [2:0]  dir,
  input  rbsi_pkg::coord_t [2:0]  box_min,
  input  rbsi_pkg::coord_t [2:0]  box_max,
  input  logic                    q_full,
  output logic                    push,
  output rbsi_pkg::item_t         item
);

  logic [2:0] outside;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    item.org = org;
    item.dir = dir;
    for (int a = 0; a < 3; a++) begin
      item.dz[a]  = (dir[a] == '0);
      outside[a]  = ($signed(org[a]) < $signed(box_min[a])) ||
                    ($signed(box_max[a]) < $signed(org[a]));
      item.dlo[a] = rbsi_pkg::diff_t'($signed(box_min[a])) -
                    rbsi_pkg::diff_t'($signed(org[a]));
      item.dhi[a] = rbsi_pkg::diff_t'($signed(box_max[a])) -
                    rbsi_pkg::diff_t'($signed(org[a]));
    end
    item.blocked = |(item.dz & outside);
  end

endmodule

### hdl/rbsi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined restoring divider, one quotient bit per stage, signed result.
// ----------------------------------------------------------------------------
module rbsi_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [rbsi_pkg::NW-1:0]   num,
  input  logic [rbsi_pkg::CB-1:0]   den,
  input  logic                      neg,
  output rbsi_pkg::quot_t           quo
);

  localparam int NW = rbsi_pkg::NW;
  localparam int CB = rbsi_pkg::CB;

  logic [CB-1:0] rem_r [NW+1];
  logic [NW-1:0] nq_r  [NW+1];
  logic [CB-1:0] d_r   [NW+1];
  logic          neg_r [NW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      nq_r[0]  <= num;
      d_r[0]   <= den;
      neg_r[0] <= neg;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [CB:0] t;
    logic [CB:0] diff;
    logic        ge;
    assign t    = {rem_r[k], nq_r[k][NW-1]};
    assign diff = t - {1'b0, d_r[k]};
    assign ge   = (t >= {1'b0, d_r[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[CB-1:0] : t[CB-1:0];
        nq_r[k+1]  <= {nq_r[k][NW-2:0], ge};
        d_r[k+1]   <= d_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  assign quo = neg_r[NW] ? -rbsi_pkg::quot_t'({1'b0, nq_r[NW]})
                         :  rbsi_pkg::quot_t'({1'b0, nq_r[NW]});

endmodule

### hdl/rbsi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_back
// Slab divisions, near/far reduction, hit point and the output register.
// ----------------------------------------------------------------------------
module rbsi_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rbsi_pkg::item_t         item,
  input  logic                    q_empty,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_hit,
  output rbsi_pkg::coord_t        out_t_near,
  output rbsi_pkg::coord_t        out_hit_x,
  output rbsi_pkg::coord_t        out_hit_y,
  output rbsi_pkg::coord_t        out_hit_z
);

  localparam int NW = rbsi_pkg::NW;
  localparam int CB = rbsi_pkg::CB;
  localparam int FB = rbsi_pkg::FB;

  logic en;
  logic out_valid_r;

  assign en  = !out_valid_r || out_ready;
  assign pop = en && !q_empty;

  // sideband line alongside the divider stages
  logic            v_r  [NW+1];
  rbsi_pkg::side_t sb_r [NW+1];

  rbsi_pkg::quot_t q_lo [3];
  rbsi_pkg::quot_t q_hi [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [CB:0] mlo, mhi;
    logic [CB-1:0] dmag;
    assign mlo  = item.dlo[a][CB] ? -item.dlo[a] : item.dlo[a];
    assign mhi  = item.dhi[a][CB] ? -item.dhi[a] : item.dhi[a];
    assign dmag = item.dir[a][CB-1] ? -item.dir[a] : item.dir[a];

    rbsi_div u_div_lo (
      .clk (clk),
      .en  (en),
      .num ({mlo[CB-1:0], {FB{1'b0}}}),
      .den (dmag),
      .neg (item.dlo[a][CB] ^ item.dir[a][CB-1]),
      .quo (q_lo[a])
    );

    rbsi_div u_div_hi (
      .clk (clk),
      .en  (en),
      .num ({mhi[CB-1:0], {FB{1'b0}}}),
      .den (dmag),
      .neg (item.dhi[a][CB] ^ item.dir[a][CB-1]),
      .quo (q_hi[a])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= '{org: item.org, dir: item.dir, dz: item.dz, blocked: item.blocked};
      for (int k = 0; k < NW; k++) begin
        sb_r[k+1] <= sb_r[k];
      end
    end
  end

  // ordering, reduction and hit point stages
  logic            a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r;
  rbsi_pkg::side_t a_sb_r, b_sb_r, c_sb_r, d_sb_r, e_sb_r, f_sb_r;
  rbsi_pkg::span_t a_sp_r [3];
  rbsi_pkg::span_t b_xy_r, b_z_r;
  logic            c_hit_r, d_hit_r, e_hit_r, f_hit_r;
  logic            c_any_r;
  rbsi_pkg::quot_t c_near_r;
  rbsi_pkg::coord_t d_tsat_r, e_tsat_r, f_tsat_r;
  rbsi_pkg::prod_t e_p_r [3];
  rbsi_pkg::scl_t  f_m_r [3];
  logic            out_hit_r;
  rbsi_pkg::coord_t out_t_near_r;
  rbsi_pkg::coord_t out_pt_r [3];

  rbsi_pkg::span_t c_sp;
  assign c_sp = rbsi_pkg::span_merge(b_xy_r, b_z_r);

  always_ff @(posedge clk) begin
    if (en) begin
      a_sb_r <= sb_r[NW];
      for (int a = 0; a < 3; a++) begin
        a_sp_r[a].ok <= !sb_r[NW].dz[a];
        a_sp_r[a].n  <= (q_hi[a] < q_lo[a]) ? q_hi[a] : q_lo[a];
        a_sp_r[a].f  <= (q_hi[a] < q_lo[a]) ? q_lo[a] : q_hi[a];
      end

      b_sb_r <= a_sb_r;
      b_xy_r <= rbsi_pkg::span_merge(a_sp_r[0], a_sp_r[1]);
      b_z_r  <= a_sp_r[2];

      c_sb_r   <= b_sb_r;
      c_any_r  <= c_sp.ok;
      c_near_r <= c_sp.n;
      c_hit_r  <= !b_sb_r.blocked && !(c_sp.ok && (c_sp.f < c_sp.n));

      d_sb_r   <= c_sb_r;
      d_hit_r  <= c_hit_r;
      d_tsat_r <= c_any_r ? rbsi_pkg::sat_q(c_near_r) : rbsi_pkg::COORD_MIN;

      e_sb_r   <= d_sb_r;
      e_hit_r  <= d_hit_r;
      e_tsat_r <= d_tsat_r;
      for (int a = 0; a < 3; a++) begin
        e_p_r[a] <= $signed(d_sb_r.dir[a]) * $signed(d_tsat_r);
      end

      f_sb_r   <= e_sb_r;
      f_hit_r  <= e_hit_r;
      f_tsat_r <= e_tsat_r;
      for (int a = 0; a < 3; a++) begin
        f_m_r[a] <= e_p_r[a][CB*2-1]
                  ? -rbsi_pkg::scl_t'((-e_p_r[a]) >>> FB)
                  :  rbsi_pkg::scl_t'(e_p_r[a] >>> FB);
      end

      out_hit_r    <= f_hit_r;
      out_t_near_r <= f_hit_r ? f_tsat_r : '0;
      for (int a = 0; a < 3; a++) begin
        out_pt_r[a] <= f_hit_r
                     ? rbsi_pkg::sat_s(rbsi_pkg::sum_t'(f_m_r[a]) +
                                       rbsi_pkg::sum_t'($signed(f_sb_r.org[a])))
                     : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NW; k++) begin
        v_r[k] <= 1'b0;
      end
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      d_v_r       <= 1'b0;
      e_v_r       <= 1'b0;
      f_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= !q_empty;
      for (int k = 0; k < NW; k++) begin
        v_r[k+1] <= v_r[k];
      end
      a_v_r       <= v_r[NW];
      b_v_r       <= a_v_r;
      c_v_r       <= b_v_r;
      d_v_r       <= c_v_r;
      e_v_r       <= d_v_r;
      f_v_r       <= e_v_r;
      out_valid_r <= f_v_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_hit    = out_hit_r;
  assign out_t_near = out_t_near_r;
  assign out_hit_x  = out_pt_r[0];
  assign out_hit_y  = out_pt_r[1];
  assign out_hit_z  = out_pt_r[2];

endmodule

### tb/tb_ray_box_slab_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_box_slab_intersect
// Self-checking bench for the ray against axis-aligned box slab test.
// ----------------------------------------------------------------------------
// Rays are sent through the valid/ready input channel. Each result is compared
// field by field with a prediction worked out in 64-bit integer arithmetic,
// or with a hand-typed value for the obvious rows of the directed table.
// Box corners are rewritten between phases: reset value, a small box, random
// boxes, inverted corners, full-range extremes, fully random corners, and the
// small box again. Both channels idle at random, except in one calm phase.
// ----------------------------------------------------------------------------
module tb_ray_box_slab_intersect;

  localparam logic [rbsi_pkg::IDX_BITS-1:0] IDX_UNUSED_A = 3'd6;
  localparam logic [rbsi_pkg::IDX_BITS-1:0] IDX_UNUSED_B = 3'd7;
  localparam rbsi_pkg::coord_t ONE = 32'sh0001_0000;
  localparam rbsi_pkg::coord_t TEN = 32'sh000A_0000;
  localparam rbsi_pkg::coord_t CMAX = rbsi_pkg::COORD_MAX;
  localparam rbsi_pkg::coord_t CMIN = rbsi_pkg::COORD_MIN;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    rbsi_pkg::coord_t [2:0] org;
    rbsi_pkg::coord_t [2:0] dir;
  } ray_t;

  typedef struct packed {
    logic                   hit;
    rbsi_pkg::coord_t       t_near;
    rbsi_pkg::coord_t [2:0] pt;
  } slab_result_t;

  typedef struct packed {
    ray_t         ray;
    logic         typed;
    slab_result_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rbsi_pkg::IDX_BITS-1:0] cfg_index = '0;
  logic [rbsi_pkg::CB-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  rbsi_pkg::coord_t in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  rbsi_pkg::coord_t in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  rbsi_pkg::coord_t out_t_near, out_hit_x, out_hit_y, out_hit_z;

  rbsi_pkg::coord_t box [6];
  slab_result_t pending_q [$];
  int errors = 0;
  int stall_cycles = 0;
  bit calm = 1'b0;

  ray_box_slab_intersect dut (.*);

  always #10 clk = ~clk;

  function automatic rbsi_pkg::coord_t clamp_coord(longint v);
    if (v > longint'(CMAX)) return CMAX;
    if (v < longint'(CMIN)) return CMIN;
    return rbsi_pkg::coord_t'(v);
  endfunction

  function automatic slab_result_t predict_slab(ray_t r);
    slab_result_t res;
    longint lo, hi, o, d, t1, t2, tn, tf, nr, fr, p;
    bit miss, any;
    rbsi_pkg::coord_t ts;
    res = '0;
    miss = 0;
    any = 0;
    nr = 0;
    fr = 0;
    for (int a = 0; a < 3; a++) begin
      lo = longint'(box[a]);
      hi = longint'(box[a + 3]);
      o = longint'(r.org[a]);
      d = longint'(r.dir[a]);
      if (d == 0) begin
        if (o < lo || o > hi) miss = 1;
      end else begin
        t1 = ((lo - o) * 65536) / d;
        t2 = ((hi - o) * 65536) / d;
        tn = (t2 < t1) ? t2 : t1;
        tf = (t2 < t1) ? t1 : t2;
        if (!any) begin
          nr = tn;
          fr = tf;
          any = 1;
        end else begin
          if (tn > nr) nr = tn;
          if (tf < fr) fr = tf;
        end
      end
    end
    if (miss || (any && fr < nr)) return res;
    ts = any ? clamp_coord(nr) : CMIN;
    res.hit = 1'b1;
    res.t_near = ts;
    for (int a = 0; a < 3; a++) begin
      p = longint'(r.dir[a]) * longint'(ts);
      res.pt[a] = clamp_coord(p / 65536 + longint'(r.org[a]));
    end
    return res;
  endfunction

  task automatic set_reg(logic [rbsi_pkg::IDX_BITS-1:0] idx, rbsi_pkg::coord_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= rbsi_pkg::REG_BOX_MAX_Z) box[idx] = val;
    @(posedge clk);
  endtask

  task automatic load_box(rbsi_pkg::coord_t mnx, rbsi_pkg::coord_t mny,
                          rbsi_pkg::coord_t mnz, rbsi_pkg::coord_t mxx,
                          rbsi_pkg::coord_t mxy, rbsi_pkg::coord_t mxz);
    set_reg(rbsi_pkg::REG_BOX_MIN_X, mnx);
    set_reg(rbsi_pkg::REG_BOX_MIN_Y, mny);
    set_reg(rbsi_pkg::REG_BOX_MIN_Z, mnz);
    set_reg(rbsi_pkg::REG_BOX_MAX_X, mxx);
    set_reg(rbsi_pkg::REG_BOX_MAX_Y, mxy);
    set_reg(rbsi_pkg::REG_BOX_MAX_Z, mxz);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_ray(ray_t r, logic typed, slab_result_t res);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_origin_x <= r.org[0];
    in_origin_y <= r.org[1];
    in_origin_z <= r.org[2];
    in_dir_x <= r.dir[0];
    in_dir_y <= r.dir[1];
    in_dir_z <= r.dir[2];
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(typed ? res : predict_slab(r));
  endtask

  function automatic rbsi_pkg::coord_t rand_span(int unsigned span);
    return rbsi_pkg::coord_t'($signed({1'b0, $urandom_range(2 * span)}) -
                              $signed({1'b0, span}));
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    bit shaped;
    shaped = $urandom_range(9) < 7;
    for (int a = 0; a < 3; a++) begin
      r.org[a] = shaped ? rand_span(32'h20_0000) : rbsi_pkg::coord_t'($urandom);
      r.dir[a] = shaped ? rand_span(32'h3_0000) : rbsi_pkg::coord_t'($urandom);
      if ($urandom_range(3) == 0) r.dir[a] = '0;
    end
    return r;
  endfunction

  function automatic rbsi_pkg::coord_t rand_coord();
    return rbsi_pkg::coord_t'($urandom);
  endfunction

  task automatic random_rays(int count);
    for (int i = 0; i < count; i++) send_ray(random_ray(), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin
    slab_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected, hit %0b", $time, out_hit);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (out_hit !== exp_r.hit) begin
          $display("%0t: hit expected %0b got %0b", $time, exp_r.hit, out_hit);
          errors++;
        end
        if (out_t_near !== exp_r.t_near) begin
          $display("%0t: t_near expected %h got %h", $time, exp_r.t_near, out_t_near);
          errors++;
        end
        if (out_hit_x !== exp_r.pt[0]) begin
          $display("%0t: hit_x expected %h got %h", $time, exp_r.pt[0], out_hit_x);
          errors++;
        end
        if (out_hit_y !== exp_r.pt[1]) begin
          $display("%0t: hit_y expected %h got %h", $time, exp_r.pt[1], out_hit_y);
          errors++;
        end
        if (out_hit_z !== exp_r.pt[2]) begin
          $display("%0t: hit_z expected %h got %h", $time, exp_r.pt[2], out_hit_z);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    row_t reset_rows [3];
    row_t small_rows [$];
    row_t rw;
    for (int i = 0; i < 6; i++) box[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero box after reset
    reset_rows[0] = '{ray: '0, typed: 1'b1, res: '{1'b1, CMIN, '0}};
    reset_rows[1] = '{ray: '{'{0, 0, ONE}, '0}, typed: 1'b1, res: '0};
    reset_rows[2] = '{ray: '{'0, '{0, 0, ONE}}, typed: 1'b0, res: '0};
    foreach (reset_rows[i]) send_ray(reset_rows[i].ray, reset_rows[i].typed,
                                      reset_rows[i].res);
    drain_results();

    load_box(-TEN, -TEN, -TEN, TEN, TEN, TEN);
    set_reg(IDX_UNUSED_A, 32'hDEAD_BEEF);
    set_reg(IDX_UNUSED_B, 32'h1234_5678);
    small_rows = '{
      '{'{'0, '{0, 0, ONE}}, 1'b1, '{1'b1, -TEN, '{0, 0, -TEN}}},
      '{'{'{0, 0, 32'sh20_0000}, '0}, 1'b1, '0},
      '{'{'0, '0}, 1'b1, '{1'b1, CMIN, '0}},
      '{'{'{0, 0, TEN}, '0}, 1'b0, '0},
      '{'{'{0, 0, -TEN}, '0}, 1'b0, '0},
      '{'{'0, '{ONE, ONE, ONE}}, 1'b0, '0},
      '{'{'0, '{-ONE, -ONE, -ONE}}, 1'b0, '0},
      '{'{'0, '{CMAX, CMAX, CMAX}}, 1'b0, '0},
      '{'{'0, '{CMIN, CMIN, CMIN}}, 1'b0, '0},
      '{'{'0, '{0, 0, 32'sh1}}, 1'b0, '0},
      '{'{'{CMAX, CMAX, CMAX}, '{CMIN, 32'sh1, 0}}, 1'b0, '0},
      '{'{'{CMIN, CMIN, CMIN}, '{CMAX, -32'sh1, CMAX}}, 1'b0, '0},
      '{'{'{CMIN, CMAX, 0}, '{32'sh1, -32'sh1, 32'sh1}}, 1'b0, '0},
      '{'{'{-32'sh14_0000, 0, 0}, '{ONE, 0, 0}}, 1'b0, '0},
      '{'{'{32'sh14_0000, 32'sh14_0000, 0}, '{-ONE, -ONE, 0}}, 1'b0, '0},
      '{'{'{32'sh14_0000, 0, 0}, '{ONE, 0, 0}}, 1'b0, '0},
      '{'{'{0, 32'sh1E_0000, 0}, '{ONE, -ONE, 0}}, 1'b0, '0},
      '{'{'{CMAX, CMIN, 0}, '{CMAX, CMIN, 0}}, 1'b0, '0}
    };
    foreach (small_rows[i]) begin
      rw = small_rows[i];
      send_ray(rw.ray, rw.typed, rw.res);
    end
    random_rays(150);
    drain_results();

    // random small boxes
    for (int k = 0; k < 3; k++) begin
      load_box(rand_span(32'h10_0000), rand_span(32'h10_0000), rand_span(32'h10_0000),
               rand_span(32'h10_0000), rand_span(32'h10_0000), rand_span(32'h10_0000));
      random_rays(80);
      drain_results();
    end

    // inverted corners on two axes
    load_box(32'sh5_0000, 32'sh5_0000, -TEN, -32'sh5_0000, -32'sh5_0000, TEN);
    random_rays(150);
    drain_results();

    // widest box, no idling
    calm = 1'b1;
    load_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    random_rays(150);
    drain_results();
    calm = 1'b0;

    // fully random corners, pause mid-stream until all results are back
    load_box(rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord());
    random_rays(75);
    drain_results();
    random_rays(75);
    drain_results();

    load_box(-TEN, -TEN, -TEN, TEN, TEN, TEN);
    random_rays(150);
    drain_results();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
